@@ design/gca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_pkg
// Shared constants, register codes and record types for the grouped column
// aggregator.
// ----------------------------------------------------------------------------
package gca_pkg;

  localparam int MAX_GROUP_ROWS = 65536;
  localparam int VALUE_BITS     = 32;
  localparam int FRACTION_BITS  = 16;

  // rows_in_group saturates one above the bound
  localparam int CNT_BITS     = $clog2(MAX_GROUP_ROWS + 2);
  localparam int SUM_BITS     = VALUE_BITS + CNT_BITS;
  localparam int SS_BITS      = 2 * VALUE_BITS + CNT_BITS;
  localparam int D_BITS       = SS_BITS + CNT_BITS;
  localparam int NUM_BITS     = D_BITS + 2 * FRACTION_BITS;
  localparam int M_BITS       = 2 * CNT_BITS;
  localparam int RES_BITS     = 64;
  localparam int ROOT_IN_BITS = 2 * RES_BITS;
  localparam int SREM_BITS    = RES_BITS + 4;
  localparam int STEP_BITS    = $clog2(((NUM_BITS > RES_BITS) ? NUM_BITS : RES_BITS) + 1);
  localparam int GRP_BITS     = 16;
  localparam int MODE_BITS    = 3;
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 3;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic [ADDR_BITS-1:0] REG_MODE_ADDR = ADDR_BITS'(0);

  localparam logic [MODE_BITS-1:0] MODE_SUM   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_COUNT = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_MIN   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MAX   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_MEAN  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_STDEV = 3'd5;

  typedef struct packed {
    logic signed [SUM_BITS-1:0]   sum;
    logic [SS_BITS-1:0]           ss;
    logic [CNT_BITS-1:0]          cnt;
    logic signed [VALUE_BITS-1:0] min;
    logic signed [VALUE_BITS-1:0] max;
    logic                         ovf;
    logic [GRP_BITS-1:0]          grp;
  } rec_t;

  typedef struct packed {
    logic dividing;
    logic div_zero;
    logic sqrt_busy;
    logic sqrt_rem_ok;
  } fin_status_t;

endpackage

@@ design/gca_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_front
// Accumulates sum, square sum, count, min and max of a group, one element a
// cycle while take is high, and pushes a closed group record to the queue.
// ----------------------------------------------------------------------------
module gca_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              take,
  input  logic [31:0]                       element_value,
  input  logic                              element_valid,
  input  logic                              group_end,
  output logic                              rec_push,
  output gca_pkg::rec_t                     rec
);
  import gca_pkg::*;

  localparam logic [CNT_BITS-1:0] MAX_ROWS = CNT_BITS'(MAX_GROUP_ROWS);
  localparam logic signed [VALUE_BITS-1:0] MIN_INIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] MAX_INIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic signed [SUM_BITS-1:0]   sum_r, sum_nxt, sum_upd;
  logic [SS_BITS-1:0]           ss_r, ss_nxt, ss_upd;
  logic [CNT_BITS-1:0]          cnt_r, cnt_nxt, cnt_upd;
  logic signed [VALUE_BITS-1:0] min_r, min_nxt, min_upd;
  logic signed [VALUE_BITS-1:0] max_r, max_nxt, max_upd;
  logic [CNT_BITS-1:0]          rows_r, rows_nxt, rows_upd;
  logic [GRP_BITS-1:0]          grp_r, grp_nxt;

  logic signed [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0]        mag;
  logic [2*VALUE_BITS-1:0]      sq;
  logic                         acc_en;

  always_comb begin
    v        = $signed(element_value[VALUE_BITS-1:0]);
    mag      = v[VALUE_BITS-1] ? (~element_value[VALUE_BITS-1:0] + VALUE_BITS'(1))
                               : element_value[VALUE_BITS-1:0];
    sq       = {{VALUE_BITS{1'b0}}, mag} * {{VALUE_BITS{1'b0}}, mag};
    rows_upd = (rows_r <= MAX_ROWS) ? rows_r + CNT_BITS'(1) : rows_r;
    acc_en   = element_valid && (rows_upd <= MAX_ROWS);
    sum_upd  = acc_en ? sum_r + SUM_BITS'(v) : sum_r;
    ss_upd   = acc_en ? ss_r + SS_BITS'(sq) : ss_r;
    cnt_upd  = acc_en ? cnt_r + CNT_BITS'(1) : cnt_r;
    min_upd  = (acc_en && v < min_r) ? v : min_r;
    max_upd  = (acc_en && v > max_r) ? v : max_r;

    rec.sum = sum_upd;
    rec.ss  = ss_upd;
    rec.cnt = cnt_upd;
    rec.min = min_upd;
    rec.max = max_upd;
    rec.ovf = rows_upd > MAX_ROWS;
    rec.grp = grp_r;
    rec_push = take && group_end;

    sum_nxt  = sum_r;
    ss_nxt   = ss_r;
    cnt_nxt  = cnt_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    rows_nxt = rows_r;
    grp_nxt  = grp_r;
    if (take) begin
      if (group_end) begin
        // close the group and start afresh
        sum_nxt  = '0;
        ss_nxt   = '0;
        cnt_nxt  = '0;
        min_nxt  = MIN_INIT;
        max_nxt  = MAX_INIT;
        rows_nxt = '0;
        grp_nxt  = grp_r + GRP_BITS'(1);
      end else begin
        sum_nxt  = sum_upd;
        ss_nxt   = ss_upd;
        cnt_nxt  = cnt_upd;
        min_nxt  = min_upd;
        max_nxt  = max_upd;
        rows_nxt = rows_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      ss_r   <= '0;
      cnt_r  <= '0;
      min_r  <= MIN_INIT;
      max_r  <= MAX_INIT;
      rows_r <= '0;
      grp_r  <= '0;
    end else begin
      sum_r  <= sum_nxt;
      ss_r   <= ss_nxt;
      cnt_r  <= cnt_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      rows_r <= rows_nxt;
      grp_r  <= grp_nxt;
    end
  end

endmodule

@@ design/gca_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_queue
// Short register queue of closed group records between front and back.
// ----------------------------------------------------------------------------
module gca_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gca_pkg::rec_t rec_in,
  output logic          full,
  input  logic          pop,
  output gca_pkg::rec_t rec_out,
  output logic          empty
);
  import gca_pkg::*;

  rec_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  always_comb begin
    full    = cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH);
    empty   = cnt_r == '0;
    rec_out = mem_r[rd_r];
    do_push = push && !full;
    do_pop  = pop && !empty;
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_r + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_r + QPTR_BITS'(1);
    end
    cnt_nxt = cnt_r + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ design/gca_final.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_final
// Turns a group record into a result: selection for sum, count, min and max,
// shift-add products, bit-serial long division and a digit-by-digit square
// root for mean and standard deviation.
// ----------------------------------------------------------------------------
module gca_final (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [gca_pkg::MODE_BITS-1:0]     mode,
  input  logic                              q_empty,
  input  gca_pkg::rec_t                     q_rec,
  output logic                              q_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic [63:0]                       result_value,
  output logic                              result_is_na,
  output logic                              group_overflow,
  output logic [15:0]                       group_number,
  output gca_pkg::fin_status_t              status
);
  import gca_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]              state_r, state_nxt;
  rec_t                    rec_r, rec_nxt;
  logic [MODE_BITS-1:0]    mode_r, mode_nxt;
  logic [D_BITS-1:0]       mul_a_r, mul_a_nxt, acc_r, acc_nxt;
  logic [SUM_BITS-1:0]     mul_b_r, mul_b_nxt;
  logic [NUM_BITS-1:0]     num_r, num_nxt;
  logic [M_BITS-1:0]       rem_r, rem_nxt, div_r, div_nxt;
  logic [STEP_BITS-1:0]    step_r, step_nxt;
  logic [ROOT_IN_BITS-1:0] sqx_r, sqx_nxt;
  logic [RES_BITS-1:0]     root_r, root_nxt;
  logic [SREM_BITS-1:0]    srem_r, srem_nxt;
  logic [RES_BITS-1:0]     val_r, val_nxt;
  logic                    na_r, na_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RES_BITS-1:0]     out_val_r, out_val_nxt;
  logic                    out_na_r, out_na_nxt, out_ovf_r, out_ovf_nxt;
  logic [GRP_BITS-1:0]     out_grp_r, out_grp_nxt;

  logic [SUM_BITS-1:0]     q_mag, mag_r;
  logic [M_BITS:0]         rem_sh;
  logic [SREM_BITS-1:0]    srem_sh, trial;
  logic [RES_BITS-1:0]     quo;

  always_comb begin
    q_mag = q_rec.sum[SUM_BITS-1] ? SUM_BITS'(-q_rec.sum) : SUM_BITS'(q_rec.sum);
    mag_r = rec_r.sum[SUM_BITS-1] ? SUM_BITS'(-rec_r.sum) : SUM_BITS'(rec_r.sum);
    rem_sh  = {rem_r, num_r[NUM_BITS-1]};
    srem_sh = {srem_r[SREM_BITS-3:0], sqx_r[ROOT_IN_BITS-1 -: 2]};
    trial   = SREM_BITS'({root_r, 2'b01});
    quo     = RES_BITS'(num_r);

    state_nxt = state_r;
    rec_nxt   = rec_r;
    mode_nxt  = mode_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    acc_nxt   = acc_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    sqx_nxt   = sqx_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    val_nxt   = val_r;
    na_nxt    = na_r;
    q_pop     = 1'b0;

    out_valid_nxt = out_valid_r && !pop;
    out_val_nxt   = out_val_r;
    out_na_nxt    = out_na_r;
    out_ovf_nxt   = out_ovf_r;
    out_grp_nxt   = out_grp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rec_nxt   = q_rec;
          mode_nxt  = mode;
          val_nxt   = '0;
          na_nxt    = 1'b0;
          state_nxt = ST_EMIT;
          unique case (mode)
            MODE_SUM:   val_nxt = RES_BITS'(q_rec.sum);
            MODE_COUNT: val_nxt = RES_BITS'(q_rec.cnt);
            MODE_MIN: begin
              if (q_rec.cnt == '0) na_nxt = 1'b1;
              else val_nxt = RES_BITS'(q_rec.min);
            end
            MODE_MAX: begin
              if (q_rec.cnt == '0) na_nxt = 1'b1;
              else val_nxt = RES_BITS'(q_rec.max);
            end
            MODE_MEAN: begin
              if (q_rec.cnt == '0) begin
                na_nxt = 1'b1;
              end else begin
                num_nxt   = NUM_BITS'(q_mag) << FRACTION_BITS;
                div_nxt   = M_BITS'(q_rec.cnt);
                rem_nxt   = '0;
                step_nxt  = STEP_BITS'(NUM_BITS);
                state_nxt = ST_DIV;
              end
            end
            MODE_STDEV: begin
              if (q_rec.cnt < CNT_BITS'(2)) begin
                na_nxt = 1'b1;
              end else begin
                mul_a_nxt = D_BITS'(q_rec.ss);
                mul_b_nxt = SUM_BITS'(q_rec.cnt);
                acc_nxt   = '0;
                div_nxt   = M_BITS'(q_rec.cnt) * M_BITS'(q_rec.cnt - CNT_BITS'(1));
                state_nxt = ST_MUL1;
              end
            end
            default: na_nxt = 1'b1;
          endcase
        end
      end
      ST_MUL1: begin
        // n times the square sum
        if (mul_b_r != '0) begin
          if (mul_b_r[0]) acc_nxt = acc_r + mul_a_r;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else begin
          mul_a_nxt = D_BITS'(mag_r);
          mul_b_nxt = mag_r;
          state_nxt = ST_MUL2;
        end
      end
      ST_MUL2: begin
        // subtract the squared sum
        if (mul_b_r != '0) begin
          if (mul_b_r[0]) acc_nxt = acc_r - mul_a_r;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end else begin
          num_nxt   = NUM_BITS'(acc_r) << (2 * FRACTION_BITS);
          rem_nxt   = '0;
          step_nxt  = STEP_BITS'(NUM_BITS);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r != '0) begin
          if (rem_sh >= {1'b0, div_r}) begin
            rem_nxt = M_BITS'(rem_sh - {1'b0, div_r});
            num_nxt = {num_r[NUM_BITS-2:0], 1'b1};
          end else begin
            rem_nxt = M_BITS'(rem_sh);
            num_nxt = {num_r[NUM_BITS-2:0], 1'b0};
          end
          step_nxt = step_r - STEP_BITS'(1);
        end else if (mode_r == MODE_MEAN) begin
          val_nxt   = rec_r.sum[SUM_BITS-1] ? -quo : quo;
          state_nxt = ST_EMIT;
        end else begin
          sqx_nxt   = ROOT_IN_BITS'(num_r);
          root_nxt  = '0;
          srem_nxt  = '0;
          step_nxt  = STEP_BITS'(RES_BITS);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (step_r != '0) begin
          if (srem_sh >= trial) begin
            srem_nxt = srem_sh - trial;
            root_nxt = {root_r[RES_BITS-2:0], 1'b1};
          end else begin
            srem_nxt = srem_sh;
            root_nxt = {root_r[RES_BITS-2:0], 1'b0};
          end
          sqx_nxt  = sqx_r << 2;
          step_nxt = step_r - STEP_BITS'(1);
        end else begin
          val_nxt   = root_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || pop) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = na_r ? '0 : val_r;
          out_na_nxt    = na_r;
          out_ovf_nxt   = rec_r.ovf;
          out_grp_nxt   = rec_r.grp;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    empty          = !out_valid_r;
    result_value   = out_val_r;
    result_is_na   = out_na_r;
    group_overflow = out_ovf_r;
    group_number   = out_grp_r;
    status.dividing    = state_r == ST_DIV;
    status.div_zero    = div_r == '0;
    status.sqrt_busy   = state_r == ST_SQRT;
    status.sqrt_rem_ok = srem_r <= SREM_BITS'({root_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    rec_r     <= rec_nxt;
    mode_r    <= mode_nxt;
    mul_a_r   <= mul_a_nxt;
    mul_b_r   <= mul_b_nxt;
    acc_r     <= acc_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    step_r    <= step_nxt;
    sqx_r     <= sqx_nxt;
    root_r    <= root_nxt;
    srem_r    <= srem_nxt;
    val_r     <= val_nxt;
    na_r      <= na_nxt;
    out_val_r <= out_val_nxt;
    out_na_r  <= out_na_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_grp_r <= out_grp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/grouped_column_aggregator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_column_aggregator
// Group-by reduction (sum, count, min, max, mean, sample stdev) of a signed
// column stream with NA skipping and end-of-group marks.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while full is low; the front folds each
// taken element into its running totals. Each closed group goes into a
// two-entry record queue, and full rises only when that queue is full. The
// back finalises one group at a time: sum, count, min, max and NA results
// are selected directly; mean runs the bit-serial divider; stdev adds the
// shift-add products over the bits of n and of |sum|, then the divider, and
// 64 square-root steps. Groups long enough to cover the back's work sustain
// one element per cycle while full is low; a stream of very short groups is
// limited by the back.
module grouped_column_aggregator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [31:0]                     in_element_value,
  input  logic                            in_element_valid,
  input  logic                            in_group_end,
  output logic                            empty,
  input  logic                            pop,
  output logic [63:0]                     out_result_value,
  output logic                            out_result_is_na,
  output logic                            out_group_overflow,
  output logic [15:0]                     out_group_number,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gca_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [gca_pkg::DATA_BITS-1:0]   pwdata,
  output logic [gca_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);
  import gca_pkg::*;

  logic [MODE_BITS-1:0] mode_r, mode_nxt;
  logic                 take, q_push, q_full, q_pop, q_empty;
  rec_t                 push_rec, head_rec;
  fin_status_t          fin_st;

  always_comb begin
    pready   = 1'b1;
    full     = q_full;
    take     = push && !q_full;
    mode_nxt = mode_r;
    if (psel && penable && pwrite && pready && paddr == REG_MODE_ADDR) begin
      mode_nxt = pwdata[MODE_BITS-1:0];
    end
    prdata = (paddr == REG_MODE_ADDR) ? DATA_BITS'(mode_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SUM;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  gca_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .element_value (in_element_value),
    .element_valid (in_element_valid),
    .group_end     (in_group_end),
    .rec_push      (q_push),
    .rec           (push_rec)
  );

  gca_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .rec_in  (push_rec),
    .full    (q_full),
    .pop     (q_pop),
    .rec_out (head_rec),
    .empty   (q_empty)
  );

  gca_final u_final (
    .clk            (clk),
    .rst_n          (rst_n),
    .mode           (mode_r),
    .q_empty        (q_empty),
    .q_rec          (head_rec),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .result_value   (out_result_value),
    .result_is_na   (out_result_is_na),
    .group_overflow (out_group_overflow),
    .group_number   (out_group_number),
    .status         (fin_st)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("group record pushed into a full queue");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fin_st.dividing |-> !fin_st.div_zero)
    else $error("division started with a zero divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    fin_st.sqrt_busy |-> fin_st.sqrt_rem_ok)
    else $error("square root remainder exceeds twice the partial root");

endmodule
